### rtl/core/bpc_pkg.sv
// Package for the button press classifier: widths, codes, reset values and
// the state and configuration structs shared by the core modules.
// No dependencies.
`default_nettype none

package bpc_pkg;

   // Width of the held-tick counter (legal range 8 to 16).
   localparam int COUNT_BITS = 8;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam int CFG_BITS       = 8;
   localparam int STOP_BITS      = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int DATA_BITS      = 8;

   // Commands (req_tuser)
   localparam logic [1:0] CMD_EDGE = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_POLL = 2'd2;

   // Event codes
   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_CLICK  = 2'd1;
   localparam logic [1:0] EV_LONG1  = 2'd2;
   localparam logic [1:0] EV_LONG2  = 2'd3;

   // Press duration codes
   localparam logic [1:0] DUR_NONE   = 2'd0;
   localparam logic [1:0] DUR_FIRST  = 2'd1;
   localparam logic [1:0] DUR_SECOND = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_LONG_PRESS    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SECOND_LONG   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RELEASE_LIMIT = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RELEASE_STOP  = 2'd3;

   // Register reset values
   localparam logic [CFG_BITS-1:0]  LONG_PRESS_RST    = 8'd60;
   localparam logic [CFG_BITS-1:0]  SECOND_LONG_RST   = 8'd120;
   localparam logic [CFG_BITS-1:0]  RELEASE_LIMIT_RST = 8'd140;
   localparam logic [STOP_BITS-1:0] RELEASE_STOP_RST  = 4'd12;

   typedef struct packed {
      logic [CFG_BITS-1:0]  long_press;
      logic [CFG_BITS-1:0]  second_long;
      logic [CFG_BITS-1:0]  release_limit;
      logic [STOP_BITS-1:0] release_stop;
   } bpc_cfg_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] held;
      logic [STOP_BITS-1:0]  released;
      logic                  timer_running;
      logic                  pressed;
      logic                  short_press;
      logic [1:0]            duration;
   } bpc_state_type;

endpackage

`default_nettype wire

### rtl/core/bpc_step.sv
// Next-state and event logic for one transaction of the button classifier.
// Purely combinational; depends on bpc_pkg.
`default_nettype none

module bpc_step
   import bpc_pkg::*;
(
   input  wire bpc_cfg_type   cfg,
   input  wire bpc_state_type cur,
   input  wire [1:0]          command,
   input  wire                pin_level,
   input  wire                events_muted,
   output bpc_state_type      nxt,
   output logic [1:0]         event_res
);

   logic [COUNT_BITS-1:0] long_ext;
   logic [COUNT_BITS-1:0] second_ext;
   logic [COUNT_BITS-1:0] limit_ext;
   logic [COUNT_BITS-1:0] held_inc;
   logic                  held_zero;

   assign long_ext   = COUNT_BITS'(cfg.long_press);
   assign second_ext = COUNT_BITS'(cfg.second_long);
   assign limit_ext  = COUNT_BITS'(cfg.release_limit);
   assign held_inc   = cur.held + 1'b1;
   assign held_zero  = (cur.held == '0);

   always_comb begin
      nxt       = cur;
      event_res = EV_NONE;
      case (command)
         CMD_EDGE: begin
            if (!pin_level) begin
               // press: only a fresh press restarts the timer
               if (held_zero) begin
                  nxt.pressed       = 1'b1;
                  nxt.short_press   = 1'b0;
                  nxt.timer_running = 1'b1;
               end
            end else begin
               if (held_zero) begin
                  nxt.timer_running = 1'b0;
                  nxt.duration      = DUR_NONE;
               end else if (cur.held < long_ext) begin
                  nxt.timer_running = 1'b0;
                  nxt.duration      = DUR_NONE;
                  nxt.short_press   = 1'b1;
                  nxt.held          = '0;
                  if (!events_muted) begin
                     event_res = EV_CLICK;
                  end
               end else if (cur.held < limit_ext) begin
                  nxt.held = '0;
               end
               nxt.pressed = 1'b0;
            end
         end
         CMD_TICK: begin
            if (cur.timer_running) begin
               if (!pin_level) begin
                  nxt.released = '0;
                  if (!(cur.held > limit_ext || cur.held == COUNT_MAX)) begin
                     nxt.held = held_inc;
                     if (held_inc == long_ext) begin
                        nxt.duration    = DUR_FIRST;
                        nxt.short_press = 1'b0;
                        event_res       = EV_LONG1;
                     end else if (held_inc == second_ext) begin
                        nxt.duration    = DUR_SECOND;
                        nxt.short_press = 1'b0;
                        event_res       = EV_LONG2;
                     end
                  end
               end else if (cur.released >= cfg.release_stop) begin
                  nxt.released      = '0;
                  nxt.held          = '0;
                  nxt.timer_running = 1'b0;
               end else begin
                  nxt.released = cur.released + 1'b1;
               end
            end
         end
         CMD_POLL: begin
            if (pin_level && cur.held >= limit_ext) begin
               nxt.held = '0;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/button_press_classifier.sv
// Top level of the button press classifier: stream ports, config registers,
// classifier state and the result register. Depends on bpc_pkg and bpc_step.
`default_nettype none

// Classifies one active-low button into click, first long press and second
// long press. Each request transaction is a pin edge, a timer tick or a
// release poll (req_tuser) carrying the sampled pin level and the mute flag
// (req_tdata); each one yields exactly one response transaction holding the
// event code and the updated key state, duration code, press flag and timer
// flag. rsp_tvalid rises in the cycle after request acceptance, and one
// transaction is accepted every cycle unless rsp_tready stalls: the classifier
// state updates in a single pass through bpc_step, and the result register frees
// up as soon as the downstream side takes it (req_tready follows rsp_tready
// while a response is pending). Configuration writes on the csr_ channel are
// always accepted and must only be issued while no response is outstanding.

module button_press_classifier
   import bpc_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   // request stream
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  wire  [DATA_BITS-1:0]      req_tdata,  // [0] pin_level, [1] events_muted
   input  wire  [1:0]                req_tuser,  // [1:0] command
   // response stream
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   output logic [DATA_BITS-1:0]      rsp_tdata,  // [1:0] event_res, [2] short_press,
                                                 // [4:3] press_duration, [5] button_down,
                                                 // [6] timer_on
   // configuration writes
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire  [CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [CFG_BITS-1:0]       csr_data
);

   bpc_cfg_type          cfg_ff, cfg_in;
   bpc_state_type        state_ff, state_nxt;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_data_ff;
   logic [1:0]           event_res;
   logic                 req_fire;

   // Result register can take a new transaction when empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   bpc_step u_step (
      .cfg          (cfg_ff),
      .cur          (state_ff),
      .command      (req_tuser),
      .pin_level    (req_tdata[0]),
      .events_muted (req_tdata[1]),
      .nxt          (state_nxt),
      .event_res    (event_res)
   );

   // Config register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_LONG_PRESS:    cfg_in.long_press    = csr_data;
            REG_SECOND_LONG:   cfg_in.second_long   = csr_data;
            REG_RELEASE_LIMIT: cfg_in.release_limit = csr_data;
            REG_RELEASE_STOP:  cfg_in.release_stop  = csr_data[STOP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press    <= LONG_PRESS_RST;
         cfg_ff.second_long   <= SECOND_LONG_RST;
         cfg_ff.release_limit <= RELEASE_LIMIT_RST;
         cfg_ff.release_stop  <= RELEASE_STOP_RST;
         state_ff             <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_nxt;
         end
      end
   end

   // Response payload, loaded on every accepted request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {1'b0, state_nxt.timer_running, state_nxt.pressed,
                         state_nxt.duration, state_nxt.short_press, event_res};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/core/bpc_checker.sv
// Port-level checks for the button press classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier.
`default_nettype none

module bpc_checker
   import bpc_pkg::*;
(
   input wire                  clock,
   input wire                  reset,
   input wire                  req_tvalid,
   input wire                  req_tready,
   input wire                  rsp_tvalid,
   input wire                  rsp_tready,
   input wire [DATA_BITS-1:0]  rsp_tdata
);

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // An accepted request always produces a response in the next cycle.
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted request without response");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // A click ends the press: short press recorded, timer off, key up.
   a_click: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == EV_CLICK) |->
         (rsp_tdata[2] && !rsp_tdata[5] && !rsp_tdata[6] && rsp_tdata[4:3] == DUR_NONE))
      else $error("click with inconsistent key state");

   // A long press event leaves the timer running and the short flag cleared.
   a_long: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == EV_LONG1 || rsp_tdata[1:0] == EV_LONG2)) |->
         (rsp_tdata[6] && !rsp_tdata[2] && rsp_tdata[4:3] != DUR_NONE))
      else $error("long press with inconsistent key state");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for button_press_classifier: stream stimulus, CSR writes,
// cycle-by-cycle prediction of every response transaction and a scoreboard.
// Depends on bpc_pkg and the button_press_classifier RTL.
`default_nettype none

module tb_top;
   import bpc_pkg::*;

   localparam int  WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
   localparam int  SETTLE_CYCLES  = 3;     // settle margin after the last response
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam logic PIN_PRESSED  = 1'b0;   // pin is active low
   localparam logic PIN_RELEASED = 1'b1;

   // Response layout on rsp_tdata, lowest bit last
   typedef struct packed {
      logic       spare;
      logic       timer_on;
      logic       button_down;
      logic [1:0] press_duration;
      logic       short_press;
      logic [1:0] event_res;
   } button_report_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [DATA_BITS-1:0]      req_tdata = '0;  // [0] pin_level, [1] events_muted
   logic [1:0]                req_tuser = '0;  // [1:0] command
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b1;
   logic [DATA_BITS-1:0]      rsp_tdata;       // [1:0] event_res, [2] short_press,
                                               // [4:3] press_duration, [5] button_down,
                                               // [6] timer_on
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_data = '0;

   // Predictor state: shadow copy of the classifier and its thresholds
   bpc_state_type     btn;
   bpc_cfg_type       thr;
   button_report_type report_q[$];   // expected responses, oldest first

   int fail_count  = 0;
   int sent_items  = 0;
   int stall_left  = 0;
   int quiet_count = 0;
   bit req_gaps_on = 1'b0;
   bit rsp_gaps_on = 1'b0;

   // Thresholds as last programmed, used only to shape stimulus
   int cur_long   = int'(LONG_PRESS_RST);
   int cur_second = int'(SECOND_LONG_RST);
   int cur_limit  = int'(RELEASE_LIMIT_RST);
   int cur_stop   = int'(RELEASE_STOP_RST);

   button_press_classifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Mostly no gap, some short, a few long.
   function automatic int pick_gap(input bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 9);
      return $urandom_range(10, 30);
   endfunction

   // Advance the shadow classifier by one request and return the response
   // it must produce.
   function automatic button_report_type classify_item(input logic [1:0] cmd,
                                                       input logic pin,
                                                       input logic muted);
      button_report_type rep;
      rep = '0;
      rep.event_res = EV_NONE;
      case (cmd)
         CMD_EDGE: begin
            if (pin == PIN_PRESSED) begin
               // a press only starts a new run when the count is clear
               if (btn.held == '0) begin
                  btn.pressed       = 1'b1;
                  btn.short_press   = 1'b0;
                  btn.timer_running = 1'b1;
               end
            end else begin
               if (btn.held == '0) begin
                  btn.timer_running = 1'b0;
                  btn.duration      = DUR_NONE;
               end else if (btn.held < thr.long_press) begin
                  // short press: click unless muted
                  btn.timer_running = 1'b0;
                  btn.duration      = DUR_NONE;
                  btn.short_press   = 1'b1;
                  btn.held          = '0;
                  if (!muted) rep.event_res = EV_CLICK;
               end else if (btn.held < thr.release_limit) begin
                  btn.held = '0;
               end
               btn.pressed = 1'b0;
            end
         end
         CMD_TICK: begin
            if (btn.timer_running) begin
               if (pin == PIN_PRESSED) begin
                  btn.released = '0;
                  // saturate one past the limit, never wrap
                  if (btn.held <= thr.release_limit && btn.held != COUNT_MAX) begin
                     btn.held = btn.held + 1'b1;
                     if (btn.held == thr.long_press) begin
                        btn.duration    = DUR_FIRST;
                        btn.short_press = 1'b0;
                        rep.event_res   = EV_LONG1;
                     end else if (btn.held == thr.second_long) begin
                        btn.duration    = DUR_SECOND;
                        btn.short_press = 1'b0;
                        rep.event_res   = EV_LONG2;
                     end
                  end
               end else if (btn.released >= thr.release_stop) begin
                  btn.released      = '0;
                  btn.held          = '0;
                  btn.timer_running = 1'b0;
               end else begin
                  btn.released = btn.released + 1'b1;
               end
            end
         end
         CMD_POLL: begin
            if (pin == PIN_RELEASED && btn.held >= thr.release_limit) btn.held = '0;
         end
         default: ;
      endcase
      rep.short_press    = btn.short_press;
      rep.press_duration = btn.duration;
      rep.button_down    = btn.pressed;
      rep.timer_on       = btn.timer_running;
      return rep;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Scoreboard: all handshakes are sampled at the rising edge. Responses are
   // checked before the request of the same edge is predicted; as the response
   // is registered, it never belongs to a request accepted at its own edge.
   always @(posedge clock) begin : scoreboard
      button_report_type want, got;
      if (reset) begin
         btn = '0;
         thr.long_press    = LONG_PRESS_RST;
         thr.second_long   = SECOND_LONG_RST;
         thr.release_limit = RELEASE_LIMIT_RST;
         thr.release_stop  = RELEASE_STOP_RST;
         report_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (report_q.size() == 0) begin
               $error("response transaction with no request outstanding");
               fail_count++;
            end else begin
               want = report_q.pop_front();
               check_field("event_res", int'(want.event_res), int'(got.event_res));
               check_field("short_press", int'(want.short_press),
                           int'(got.short_press));
               check_field("press_duration", int'(want.press_duration),
                           int'(got.press_duration));
               check_field("button_down", int'(want.button_down),
                           int'(got.button_down));
               check_field("timer_on", int'(want.timer_on), int'(got.timer_on));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LONG_PRESS:    thr.long_press    = csr_data;
               REG_SECOND_LONG:   thr.second_long   = csr_data;
               REG_RELEASE_LIMIT: thr.release_limit = csr_data;
               REG_RELEASE_STOP:  thr.release_stop  = csr_data[STOP_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            report_q.push_back(classify_item(req_tuser, req_tdata[0], req_tdata[1]));
      end
   end

   // Downstream backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= pick_gap(rsp_gaps_on);
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: any transaction on any channel resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_count <= 0;
      end else if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // One request transaction. tvalid stays high after acceptance so that a
   // following item can go out on the very next cycle.
   task automatic send_item(input logic [1:0] cmd, input logic pin, input logic muted);
      int gap;
      gap = pick_gap(req_gaps_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(DATA_BITS-2){1'b0}}, muted, pin};
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   // Stop sending and wait until every expected response has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (report_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_thresholds(input int long_t, input int second_t,
                                     input int limit_t, input int stop_t);
      wait_idle();
      write_reg(REG_LONG_PRESS, CFG_BITS'(long_t));
      write_reg(REG_SECOND_LONG, CFG_BITS'(second_t));
      write_reg(REG_RELEASE_LIMIT, CFG_BITS'(limit_t));
      write_reg(REG_RELEASE_STOP, CFG_BITS'(stop_t));
      csr_valid  <= 1'b0;
      cur_long   = long_t;
      cur_second = second_t;
      cur_limit  = limit_t;
      cur_stop   = stop_t;
   endtask

   function automatic logic rand_mute();
      return ($urandom_range(0, 3) == 0);
   endfunction

   // Reset thresholds: unused command, idle tick and poll, zero-count release,
   // repeated press, press with a running count, click and muted click.
   task automatic test_basic_edges();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      send_item(CMD_UNUSED, PIN_RELEASED, 1'b1);
      send_item(CMD_TICK, PIN_PRESSED, 1'b0);
      send_item(CMD_POLL, PIN_RELEASED, 1'b0);
      send_item(CMD_EDGE, PIN_RELEASED, 1'b0);
      send_item(CMD_EDGE, PIN_PRESSED, 1'b0);
      send_item(CMD_EDGE, PIN_PRESSED, 1'b1);
      send_item(CMD_TICK, PIN_PRESSED, 1'b0);
      send_item(CMD_EDGE, PIN_PRESSED, 1'b0);
      send_item(CMD_EDGE, PIN_RELEASED, 1'b0);
      send_item(CMD_EDGE, PIN_PRESSED, 1'b1);
      send_item(CMD_TICK, PIN_PRESSED, 1'b1);
      send_item(CMD_EDGE, PIN_RELEASED, 1'b1);
      send_item(CMD_TICK, PIN_RELEASED, 1'b0);
      send_item(CMD_UNUSED, PIN_PRESSED, 1'b0);
   endtask

   // Both long events, saturation past a small limit, release past the
   // limit, poll clearing, and the timer stop after released ticks.
   task automatic test_long_events();
      program_thresholds(2, 4, 5, 1);
      rsp_gaps_on = 1'b1;
      send_item(CMD_EDGE, PIN_PRESSED, 1'b0);
      repeat (7) send_item(CMD_TICK, PIN_PRESSED, 1'b0);
      send_item(CMD_POLL, PIN_PRESSED, 1'b0);
      send_item(CMD_EDGE, PIN_RELEASED, 1'b0);
      send_item(CMD_POLL, PIN_RELEASED, 1'b1);
      send_item(CMD_TICK, PIN_RELEASED, 1'b0);
      send_item(CMD_TICK, PIN_RELEASED, 1'b0);
      // release between the first long and the limit keeps the timer running
      send_item(CMD_EDGE, PIN_PRESSED, 1'b0);
      repeat (3) send_item(CMD_TICK, PIN_PRESSED, 1'b1);
      send_item(CMD_EDGE, PIN_RELEASED, 1'b0);
      repeat (2) send_item(CMD_TICK, PIN_RELEASED, 1'b0);
   endtask

   // Long, second and limit thresholds at one, stop at zero: the first long
   // event wins, and a press is ignored while a saturated count waits for a poll.
   task automatic test_low_extremes();
      program_thresholds(1, 1, 1, 0);
      req_gaps_on = 1'b1;
      send_item(CMD_EDGE, PIN_PRESSED, 1'b0);
      repeat (3) send_item(CMD_TICK, PIN_PRESSED, 1'b0);
      send_item(CMD_EDGE, PIN_RELEASED, 1'b0);
      send_item(CMD_EDGE, PIN_PRESSED, 1'b0);
      send_item(CMD_TICK, PIN_RELEASED, 1'b0);
      send_item(CMD_POLL, PIN_RELEASED, 1'b0);
      send_item(CMD_EDGE, PIN_PRESSED, 1'b0);
   endtask

   // Count pinned at the top of the counter range with the widest limits.
   task automatic test_count_saturation();
      program_thresholds(254, 254, 254, 15);
      send_item(CMD_EDGE, PIN_PRESSED, 1'b0);
      repeat (258) send_item(CMD_TICK, PIN_PRESSED, 1'($urandom_range(0, 1)));
      send_item(CMD_EDGE, PIN_RELEASED, 1'b0);
      repeat (3) send_item(CMD_TICK, PIN_RELEASED, 1'b0);
      send_item(CMD_POLL, PIN_RELEASED, 1'b0);
      repeat (14) send_item(CMD_TICK, PIN_RELEASED, 1'b0);
   endtask

   // Stop tolerance lowered under the released count of a live timer.
   task automatic test_stop_lowered();
      program_thresholds(10, 20, 30, 15);
      send_item(CMD_EDGE, PIN_PRESSED, 1'b0);
      send_item(CMD_TICK, PIN_PRESSED, 1'b0);
      repeat (6) send_item(CMD_TICK, PIN_RELEASED, 1'b0);
      wait_idle();
      write_reg(REG_RELEASE_STOP, CFG_BITS'(2));
      csr_valid <= 1'b0;
      cur_stop = 2;
      send_item(CMD_TICK, PIN_RELEASED, 1'b0);
      send_item(CMD_EDGE, PIN_RELEASED, 1'b0);
   endtask

   // One press and release with random content, or a burst of noise.
   task automatic run_press_session();
      int top, held_n, rel_n, k;
      logic [1:0] cmd;
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
               0, 1, 2:    cmd = CMD_EDGE;
               3, 4, 5, 6: cmd = CMD_TICK;
               7, 8:       cmd = CMD_POLL;
               default:    cmd = CMD_UNUSED;
            endcase
            send_item(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
         return;
      end
      top = cur_long;
      if (cur_second > top) top = cur_second;
      if (cur_limit > top) top = cur_limit;
      held_n = ($urandom_range(0, 1) == 0) ? $urandom_range(0, cur_long + 1)
                                           : $urandom_range(0, top + 3);
      send_item(CMD_EDGE, PIN_PRESSED, rand_mute());
      for (k = 0; k < held_n; k++) begin
         if ($urandom_range(0, 29) == 0)
            send_item(CMD_POLL, 1'($urandom_range(0, 1)), rand_mute());
         // occasional bounce while held
         send_item(CMD_TICK, ($urandom_range(0, 15) == 0) ? PIN_RELEASED : PIN_PRESSED,
                   rand_mute());
      end
      if ($urandom_range(0, 9) != 0)
         send_item(CMD_EDGE, PIN_RELEASED, rand_mute());
      rel_n = $urandom_range(0, cur_stop + 2);
      for (k = 0; k < rel_n; k++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(CMD_POLL, 1'($urandom_range(0, 1)), rand_mute());
         send_item(CMD_TICK, PIN_RELEASED, rand_mute());
      end
      if ($urandom_range(0, 3) == 0)
         send_item(CMD_POLL, PIN_RELEASED, rand_mute());
   endtask

   // Phases of random thresholds; one phase with large values, one with an
   // early second threshold, and gaps switched on and off per phase.
   task automatic test_random_sessions();
      int phase, goal;
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            2: program_thresholds($urandom_range(200, 254), $urandom_range(200, 254),
                                  $urandom_range(230, 254), $urandom_range(8, 15));
            4: program_thresholds($urandom_range(4, 8), $urandom_range(1, 3),
                                  $urandom_range(5, 12), $urandom_range(0, 4));
            default: program_thresholds($urandom_range(1, 12), $urandom_range(1, 16),
                                        $urandom_range(1, 20), $urandom_range(0, 15));
         endcase
         req_gaps_on = (phase % 3 != 0);
         rsp_gaps_on = (phase % 2 != 0);
         goal = sent_items + 80;
         while (sent_items < goal) run_press_session();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_basic_edges();
      test_long_events();
      test_low_extremes();
      test_count_saturation();
      test_stop_lowered();
      test_random_sessions();
      wait_idle();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
